/* rtl/wmhe_pkg.sv */
// Shared constants, types and helpers for the mesh histogram entropy block.
package wmhe_pkg;

    localparam int BINS_X    = 16;
    localparam int BINS_Y    = 16;
    localparam int BINS_Z    = 16;
    localparam int ACC_WIDTH = 48;
    localparam int NBINS     = BINS_X * BINS_Y * BINS_Z;
    localparam int BX_W      = (BINS_X > 1) ? $clog2(BINS_X) : 1;
    localparam int BY_W      = (BINS_Y > 1) ? $clog2(BINS_Y) : 1;
    localparam int BZ_W      = (BINS_Z > 1) ? $clog2(BINS_Z) : 1;
    localparam int ADDR_W    = $clog2(NBINS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int EMPTY_W   = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REPORT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] MODE_ALL = 2'd0;
    localparam logic [1:0] MODE_POS = 2'd1;
    localparam logic [1:0] MODE_NEG = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIGN   = 3'd6;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    typedef logic signed [ACC_WIDTH-1:0] acc_t;

    // Saturating signed add of a 32-bit weight to an accumulator.
    function automatic acc_t sat_add(input acc_t acc, input logic signed [31:0] w);
        logic signed [ACC_WIDTH:0] s;
        begin
            s = {acc[ACC_WIDTH-1], acc} + (ACC_WIDTH + 1)'(w);
            if (s > (ACC_WIDTH + 1)'(ACC_MAX)) begin
                sat_add = ACC_MAX;
            end else if (s < (ACC_WIDTH + 1)'(ACC_MIN)) begin
                sat_add = ACC_MIN;
            end else begin
                sat_add = s[ACC_WIDTH-1:0];
            end
        end
    endfunction

    function automatic logic [ACC_WIDTH-1:0] mag(input acc_t v);
        begin
            mag = v[ACC_WIDTH-1] ? (ACC_WIDTH)'(-v) : v;
        end
    endfunction

endpackage

/* rtl/wmhe_ram.sv */
// Generic single-port RAM with registered read.
module wmhe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/wmhe_term.sv */
// Iterative entropy term unit: restoring divide, then log2 by repeated squaring.
module wmhe_term (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [wmhe_pkg::ACC_WIDTH-1:0]   num,
    input  logic [wmhe_pkg::ACC_WIDTH-1:0]   den,
    output logic                             done,
    output logic [31:0]                      term
);
    import wmhe_pkg::*;

    typedef enum logic [4:0] {
        T_IDLE = 5'b00001,
        T_DIV  = 5'b00010,
        T_NORM = 5'b00100,
        T_SQR  = 5'b01000,
        T_MUL  = 5'b10000
    } tstate_t;

    tstate_t state_reg, state_next;
    logic [ACC_WIDTH:0]   rem_reg, rem_next;
    logic [ACC_WIDTH-1:0] den_reg, den_next;
    logic [31:0]          q_reg, q_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [4:0]           e_reg, e_next;
    logic [32:0]          m_reg, m_next;
    logic [23:0]          f_reg, f_next;
    logic [31:0]          term_reg, term_next;
    logic                 done_reg, done_next;

    logic [ACC_WIDTH:0] rem_sh;
    logic [65:0]        sq;
    logic [63:0]        sq_sh;
    logic [31:0]        nlog;
    logic [63:0]        prod;

    always_comb begin
        rem_sh = {rem_reg[ACC_WIDTH-1:0], 1'b0};
        sq     = {33'd0, m_reg} * {33'd0, m_reg};
        sq_sh  = sq[65:2] >> 29;
        nlog   = ({26'd0, 6'd32 - {1'b0, e_reg}} << 24) - {8'd0, f_reg};
        prod   = q_reg * nlog;
    end

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        e_next     = e_reg;
        m_next     = m_reg;
        f_next     = f_reg;
        term_next  = term_reg;
        done_next  = 1'b0;
        case (state_reg)
            T_IDLE: begin
                if (start) begin
                    rem_next   = {1'b0, num};
                    den_next   = den;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = T_DIV;
                end
            end
            T_DIV: begin
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    q_next   = {q_reg[30:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    e_next     = 5'd31;
                    state_next = T_NORM;
                end
            end
            T_NORM: begin
                if (q_reg == '0) begin
                    term_next  = '0;
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end else if (e_reg != 5'd0 && q_reg[e_reg] == 1'b0) begin
                    e_next = e_reg - 5'd1;
                end else begin
                    m_next     = {1'b0, q_reg << (5'd31 - e_reg)};
                    f_next     = '0;
                    cnt_next   = '0;
                    state_next = T_SQR;
                end
            end
            T_SQR: begin
                if (sq_sh[32]) begin
                    m_next = sq_sh[33:1];
                    f_next = {f_reg[22:0], 1'b1};
                end else begin
                    m_next = sq_sh[32:0];
                    f_next = {f_reg[22:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd23) begin
                    state_next = T_MUL;
                end
            end
            T_MUL: begin
                term_next  = prod[63:32];
                done_next  = 1'b1;
                state_next = T_IDLE;
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        e_reg    <= e_next;
        m_reg    <= m_next;
        f_reg    <= f_next;
        term_reg <= term_next;
    end

    assign done = done_reg;
    assign term = term_reg;
endmodule

/* rtl/weighted_mesh_histogram_entropy.sv */
// Top level: weighted 3D mesh histogram with Shannon entropy report.
// Add: busy after accept (up to three axis products on one multiplier,
// then a bin read-modify-write). Clear: one bin per cycle. Report: per bin
// a read and a check; empty, full or overweight bins skip the divide/log unit,
// others go through it; then the result waits for a free output register.
// After reset a clearing pass over all NBINS (4096) bins zeroes the bin memory; no word is
// accepted meanwhile. Reset is synchronous, active low; control registers return to defaults.
module weighted_mesh_histogram_entropy (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // op[1:0], pos_x[33:2], pos_y[65:34], pos_z[97:66], weight[129:98], zero fill
    input  logic [135:0]                      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // entropy_value[31:0], empty_bins[44:32], overweight_flag[45],
    // zero_total_flag[46], zero fill
    output logic [47:0]                       m_tdata,
    input  logic                              cfg_we,
    input  logic [wmhe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_wdata
);
    import wmhe_pkg::*;

    typedef enum logic [10:0] {
        S_INIT  = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_AXIS  = 11'b00000000100,
        S_ARD   = 11'b00000001000,
        S_AWR   = 11'b00000010000,
        S_CLR   = 11'b00000100000,
        S_RRD   = 11'b00001000000,
        S_RWAIT = 11'b00010000000,
        S_RCHK  = 11'b00100000000,
        S_RTERM = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] low_x_reg, low_y_reg, low_z_reg;
    logic [31:0]        inv_x_reg, inv_y_reg, inv_z_reg;
    logic [1:0]         mode_reg;

    logic signed [31:0] px_reg, py_reg, pz_reg, w_reg, px_next, py_next, pz_next, w_next;
    logic [1:0]         axis_reg, axis_next;
    logic [BX_W-1:0]    nx_reg, nx_next;
    logic [BY_W-1:0]    ny_reg, ny_next;
    logic [BZ_W-1:0]    nz_reg, nz_next;
    acc_t               tot_reg, tot_next;
    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic [31:0]        sum_reg, sum_next;
    logic [EMPTY_W-1:0] empty_reg, empty_next;
    logic               over_reg, over_next;
    logic [ACC_WIDTH-1:0] bmag_reg, bmag_next;
    logic               mval_reg, mval_next;
    logic [47:0]        mdata_reg, mdata_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [ACC_WIDTH-1:0] ram_wdata, ram_rdata;

    logic                 term_start, term_done;
    logic [31:0]          term_val;
    logic [ACC_WIDTH-1:0] tot_mag;

    logic signed [31:0] a_pos, a_low;
    logic [31:0]        a_inv;
    logic signed [32:0] a_diff;
    logic [63:0]        a_prod;
    logic [31:0]        a_k;
    logic               a_ok;
    logic               take;
    logic [32:0]        sum_add;

    wmhe_ram #(.WIDTH(ACC_WIDTH), .DEPTH(NBINS)) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    wmhe_term u_term (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (term_start),
        .num     (bmag_reg),
        .den     (tot_mag),
        .done    (term_done),
        .term    (term_val)
    );

    assign tot_mag = mag(tot_reg);

    always_comb begin
        case (axis_reg)
            2'd0: begin a_pos = px_reg; a_low = low_x_reg; a_inv = inv_x_reg; end
            2'd1: begin a_pos = py_reg; a_low = low_y_reg; a_inv = inv_y_reg; end
            default: begin a_pos = pz_reg; a_low = low_z_reg; a_inv = inv_z_reg; end
        endcase
        a_diff = 33'(a_pos) - 33'(a_low);
        a_prod = a_diff[31:0] * a_inv;
        a_k    = (a_inv == '0) ? 32'd0 : (a_diff[32] ? 32'd0 : a_prod[63:32]);
        case (axis_reg)
            2'd0: a_ok = (a_inv == '0) || (!a_diff[32] && a_k < 32'(BINS_X));
            2'd1: a_ok = (a_inv == '0) || (!a_diff[32] && a_k < 32'(BINS_Y));
            default: a_ok = (a_inv == '0) || (!a_diff[32] && a_k < 32'(BINS_Z));
        endcase
        case (mode_reg)
            MODE_ALL: take = 1'b1;
            MODE_POS: take = (w_reg > 0);
            MODE_NEG: take = (w_reg <= 0);
            default:  take = 1'b0;
        endcase
        sum_add = {1'b0, sum_reg} + {1'b0, term_val};
    end

    always_comb begin
        state_next = state_reg;
        px_next = px_reg; py_next = py_reg; pz_next = pz_reg; w_next = w_reg;
        axis_next  = axis_reg;
        nx_next = nx_reg; ny_next = ny_reg; nz_next = nz_reg;
        tot_next   = tot_reg;
        addr_next  = addr_reg;
        sum_next   = sum_reg;
        empty_next = empty_reg;
        over_next  = over_reg;
        bmag_next  = bmag_reg;
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        ram_we     = 1'b0;
        ram_addr   = addr_reg[ADDR_W-1:0];
        ram_wdata  = '0;
        term_start = 1'b0;
        s_tready   = 1'b0;
        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end
        case (state_reg)
            S_INIT, S_CLR: begin
                ram_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                tot_next  = '0;
                if (addr_reg == CNT_W'(NBINS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    px_next  = s_tdata[33:2];
                    py_next  = s_tdata[65:34];
                    pz_next  = s_tdata[97:66];
                    w_next   = s_tdata[129:98];
                    axis_next = 2'd0;
                    addr_next = '0;
                    sum_next  = '0;
                    empty_next = '0;
                    over_next = 1'b0;
                    case (s_tdata[1:0])
                        OP_ADD:    state_next = S_AXIS;
                        OP_CLEAR:  state_next = S_CLR;
                        OP_REPORT: state_next = S_RRD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_AXIS: begin
                if (!a_ok) begin
                    state_next = S_IDLE;
                end else begin
                    axis_next = axis_reg + 2'd1;
                    case (axis_reg)
                        2'd0: nx_next = a_k[BX_W-1:0];
                        2'd1: ny_next = a_k[BY_W-1:0];
                        default: begin
                            nz_next    = a_k[BZ_W-1:0];
                            tot_next   = sat_add(tot_reg, w_reg);
                            state_next = take ? S_ARD : S_IDLE;
                        end
                    endcase
                end
            end
            S_ARD: begin
                ram_addr   = ADDR_W'(({20'd0, nx_reg} * BINS_Y + ny_reg) * BINS_Z + nz_reg);
                state_next = S_AWR;
            end
            S_AWR: begin
                ram_addr   = ADDR_W'(({20'd0, nx_reg} * BINS_Y + ny_reg) * BINS_Z + nz_reg);
                ram_we     = 1'b1;
                ram_wdata  = sat_add(ram_rdata, w_reg);
                state_next = S_IDLE;
            end
            S_RRD: begin
                state_next = S_RWAIT;
            end
            S_RWAIT: begin
                bmag_next  = mag(ram_rdata);
                state_next = S_RCHK;
            end
            S_RCHK: begin
                if (bmag_reg == '0) begin
                    if (empty_reg != {EMPTY_W{1'b1}}) begin
                        empty_next = empty_reg + 1'b1;
                    end
                    state_next = S_RTERM;
                end else if (bmag_reg > tot_mag) begin
                    over_next  = 1'b1;
                    state_next = S_RTERM;
                end else if (bmag_reg == tot_mag) begin
                    state_next = S_RTERM;
                end else begin
                    term_start = 1'b1;
                    state_next = S_RTERM;
                end
            end
            S_RTERM: begin
                if (term_done || bmag_reg == '0 || bmag_reg >= tot_mag) begin
                    if (term_done) begin
                        sum_next = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
                    end
                    addr_next = addr_reg + 1'b1;
                    state_next = (addr_reg == CNT_W'(NBINS - 1)) ? S_OUT : S_RRD;
                end
            end
            S_OUT: begin
                if (!mval_reg) begin
                    mval_next  = 1'b1;
                    mdata_next = {1'b0, (tot_mag == '0), over_reg, empty_reg,
                                  (tot_mag == '0) ? 32'd0 : sum_reg};
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            addr_reg  <= '0;
            tot_reg   <= '0;
            mval_reg  <= 1'b0;
            low_x_reg <= '0;
            low_y_reg <= '0;
            low_z_reg <= '0;
            inv_x_reg <= 32'd65536;
            inv_y_reg <= 32'd65536;
            inv_z_reg <= 32'd65536;
            mode_reg  <= MODE_ALL;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            tot_reg   <= tot_next;
            mval_reg  <= mval_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_LOW_X: low_x_reg <= cfg_wdata;
                    REG_LOW_Y: low_y_reg <= cfg_wdata;
                    REG_LOW_Z: low_z_reg <= cfg_wdata;
                    REG_INV_X: inv_x_reg <= cfg_wdata;
                    REG_INV_Y: inv_y_reg <= cfg_wdata;
                    REG_INV_Z: inv_z_reg <= cfg_wdata;
                    REG_SIGN:  mode_reg  <= cfg_wdata[1:0];
                    default:   mode_reg  <= mode_reg;
                endcase
            end
        end
        px_reg <= px_next; py_reg <= py_next; pz_reg <= pz_next; w_reg <= w_next;
        axis_reg  <= axis_next;
        nx_reg <= nx_next; ny_reg <= ny_next; nz_reg <= nz_next;
        sum_reg   <= sum_next;
        empty_reg <= empty_next;
        over_reg  <= over_next;
        bmag_reg  <= bmag_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input accepted while busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped under stall");

    a_term_only_report: assert property (@(posedge aclk) disable iff (!aresetn)
        term_done |-> (state_reg == S_RTERM))
        else $error("term unit finished outside report walk");

endmodule
